@@ design/bee_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bee_pkg
// Shared types and constants of the backslash escape encoder: request and
// result payloads, option bits, escape sequence and register addresses.
// ----------------------------------------------------------------------------
package bee_pkg;

  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned SEQ_LEN = 4;
  localparam int unsigned SEQ_IDX_W = 2;

  typedef logic [1:0] reg_idx_t;

  localparam reg_idx_t REG_ESCAPE_PERCENT    = 2'd0;
  localparam reg_idx_t REG_ESCAPE_QUOTE      = 2'd1;
  localparam reg_idx_t REG_ESCAPE_SPACE_RUNS = 2'd2;

  typedef struct packed {
    logic [7:0] char_in;
    logic [7:0] next_char;
    logic       has_next;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic escape_percent;
    logic escape_quote;
    logic escape_space_runs;
  } cfg_t;

  typedef struct packed {
    logic [SEQ_LEN-1:0][7:0] bytes;
    logic [SEQ_IDX_W-1:0]    last_idx;
  } esc_seq_t;

endpackage

@@ design/bee_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bee_cfg_regs
// APB-style register file holding the three escape option bits.
// ----------------------------------------------------------------------------
module bee_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bee_pkg::ADDR_W-1:0]    paddr,
  input  logic [bee_pkg::DATA_W-1:0]    pwdata,
  output logic [bee_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output bee_pkg::cfg_t                 cfg
);

  bee_pkg::reg_idx_t idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (idx)
        bee_pkg::REG_ESCAPE_PERCENT:    cfg.escape_percent    <= pwdata[0];
        bee_pkg::REG_ESCAPE_QUOTE:      cfg.escape_quote      <= pwdata[0];
        bee_pkg::REG_ESCAPE_SPACE_RUNS: cfg.escape_space_runs <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      bee_pkg::REG_ESCAPE_PERCENT:    prdata[0] = cfg.escape_percent;
      bee_pkg::REG_ESCAPE_QUOTE:      prdata[0] = cfg.escape_quote;
      bee_pkg::REG_ESCAPE_SPACE_RUNS: prdata[0] = cfg.escape_space_runs;
      default:                        prdata    = '0;
    endcase
  end

endmodule

@@ design/bee_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bee_in_stage
// Input register: holds one request until the serializer takes it.
// ----------------------------------------------------------------------------
module bee_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  bee_pkg::in_item_t in_data,
  input  logic              take,
  output logic              held_valid,
  output bee_pkg::in_item_t held
);

  logic accept;

  assign in_stall = held_valid && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= in_data;
    end
  end

endmodule

@@ design/bee_escape_logic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bee_escape_logic
// Maps one byte and its successor to an escape sequence of one to four bytes.
// ----------------------------------------------------------------------------
module bee_escape_logic (
  input  bee_pkg::in_item_t item,
  input  bee_pkg::cfg_t     cfg,
  output bee_pkg::esc_seq_t seq
);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_HT    = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  localparam logic [1:0] LAST_PLAIN = 2'd0;
  localparam logic [1:0] LAST_PAIR  = 2'd1;
  localparam logic [1:0] LAST_HEX   = 2'd3;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] d;
    d = (v < 4'd10) ? (8'h30 + {4'd0, v}) : (8'h37 + {4'd0, v});
    return d;
  endfunction

  logic [7:0] ch;
  logic       as_hex;
  logic       as_pair;
  logic [7:0] letter;

  assign ch = item.char_in;

  always_comb begin
    as_hex  = 1'b0;
    as_pair = 1'b0;
    letter  = CH_BSL;
    unique case (ch)
      CH_NUL: begin as_pair = 1'b1; letter = "0"; end
      CH_BEL: begin as_pair = 1'b1; letter = "a"; end
      CH_BS:  begin as_pair = 1'b1; letter = "b"; end
      CH_FF:  begin as_pair = 1'b1; letter = "f"; end
      CH_LF:  begin as_pair = 1'b1; letter = "n"; end
      CH_CR:  begin as_pair = 1'b1; letter = "r"; end
      CH_HT:  begin as_pair = 1'b1; letter = "t"; end
      CH_VT:  begin as_pair = 1'b1; letter = "v"; end
      CH_BSL: begin as_pair = 1'b1; letter = CH_BSL; end
      CH_SPACE: begin
        as_pair = cfg.escape_space_runs && item.has_next && (item.next_char == CH_SPACE);
        letter  = "s";
      end
      CH_PCT: as_hex = cfg.escape_percent;
      CH_QUOTE: begin
        as_pair = cfg.escape_quote;
        letter  = "q";
      end
      CH_AMP, CH_LT, CH_GT: as_hex = 1'b1;
      default: as_hex = (ch < CH_SPACE) || (ch > CH_DEL);
    endcase
  end

  always_comb begin
    seq.bytes[0] = ch;
    seq.bytes[1] = letter;
    seq.bytes[2] = hex_digit(ch[7:4]);
    seq.bytes[3] = hex_digit(ch[3:0]);
    seq.last_idx = LAST_PLAIN;
    if (as_hex) begin
      seq.bytes[0] = CH_BSL;
      seq.bytes[1] = "x";
      seq.last_idx = LAST_HEX;
    end else if (as_pair) begin
      seq.bytes[0] = CH_BSL;
      seq.last_idx = LAST_PAIR;
    end
  end

endmodule

@@ design/bee_out_serializer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bee_out_serializer
// Result register: holds one escape sequence and sends it a byte per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module bee_out_serializer (
  input  logic               clk,
  input  logic               rst,
  input  logic               load_valid,
  input  bee_pkg::esc_seq_t  load_seq,
  output logic               take,
  output logic               out_valid,
  input  logic               out_stall,
  output bee_pkg::out_item_t out_data
);

  localparam logic [bee_pkg::SEQ_IDX_W-1:0] POS_ONE = {{(bee_pkg::SEQ_IDX_W-1){1'b0}}, 1'b1};

  bee_pkg::esc_seq_t                  seq;
  logic [bee_pkg::SEQ_IDX_W-1:0]      pos;
  logic                               last;
  logic                               sent;

  assign last  = (pos == seq.last_idx);
  assign sent  = out_valid && !out_stall;
  assign take  = load_valid && (!out_valid || (sent && last));

  assign out_data.out_char    = seq.bytes[pos];
  assign out_data.last_of_run = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else if (take) begin
      out_valid <= 1'b1;
      pos       <= '0;
    end else if (sent) begin
      if (last) begin
        out_valid <= 1'b0;
        pos       <= '0;
      end else begin
        pos <= pos + POS_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      seq <= load_seq;
    end
  end

endmodule

@@ design/backslash_escape_encoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// backslash_escape_encoder_top
// A request passes through the input register and then the output serializer.
// Throughput: one output byte per cycle while out_stall is low; each request
// gives one to four bytes, set by its escape sequence in the output serializer.
// A new request is taken while the previous sequence drains.
// Reset (synchronous, active high) empties both stages and clears options.
// ----------------------------------------------------------------------------
module backslash_escape_encoder_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  bee_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output bee_pkg::out_item_t         out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bee_pkg::ADDR_W-1:0] paddr,
  input  logic [bee_pkg::DATA_W-1:0] pwdata,
  output logic [bee_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  bee_pkg::cfg_t     cfg;
  bee_pkg::in_item_t held;
  logic              held_valid;
  logic              take;
  bee_pkg::esc_seq_t seq;

  bee_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bee_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .take       (take),
    .held_valid (held_valid),
    .held       (held)
  );

  bee_escape_logic u_esc (
    .item (held),
    .cfg  (cfg),
    .seq  (seq)
  );

  bee_out_serializer u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (held_valid),
    .load_seq   (seq),
    .take       (take),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
